// File: rtl/tilt_pkg.sv
// ============================================================================
// Tilt angle package
// Widths, CORDIC angle table and shared types for the tilt angle pipeline.
// ============================================================================
package tilt_pkg;

    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int TABLE_LEN       = 24;
    localparam int NUM_STAGES      = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    localparam int SQ_W   = 33;          // a*a + b*b, unsigned
    localparam int ROOT_W = 33;          // floor(sqrt(sq * 2^32)), < 2^31.5
    localparam int CV_W   = 36;          // CORDIC x/y datapath, signed
    localparam int ANG_W  = 33;          // Q30 angle accumulator, signed
    localparam int OUT_W  = 15;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_X_OFFSET = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_Z_OFFSET = 2'd2;

    localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 33'sd1686629713;

    typedef logic signed [15:0] sample_t;
    typedef logic signed [OUT_W-1:0] angle_t;

    function automatic logic signed [ANG_W-1:0] atan_q30(input int i);
        logic signed [ANG_W-1:0] v;
        unique case (i)
            0:  v = 33'sd843314857;
            1:  v = 33'sd497837829;
            2:  v = 33'sd263043837;
            3:  v = 33'sd133525159;
            4:  v = 33'sd67021687;
            5:  v = 33'sd33543516;
            6:  v = 33'sd16775851;
            7:  v = 33'sd8388437;
            8:  v = 33'sd4194283;
            9:  v = 33'sd2097149;
            10: v = 33'sd1048576;
            11: v = 33'sd524288;
            12: v = 33'sd262144;
            13: v = 33'sd131072;
            14: v = 33'sd65536;
            15: v = 33'sd32768;
            16: v = 33'sd16384;
            17: v = 33'sd8192;
            18: v = 33'sd4096;
            19: v = 33'sd2048;
            20: v = 33'sd1024;
            21: v = 33'sd512;
            22: v = 33'sd256;
            default: v = 33'sd128;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/tilt_if.sv
// ============================================================================
// Tilt stream interfaces
// Valid/ready channels for sample words and angle words.
// ============================================================================
interface tilt_sample_if;
    logic valid;
    logic ready;
    tilt_pkg::sample_t accel_x;
    tilt_pkg::sample_t accel_y;
    tilt_pkg::sample_t accel_z;
    modport source (output valid, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tilt_angle_if;
    logic valid;
    logic ready;
    tilt_pkg::angle_t roll_angle;
    tilt_pkg::angle_t pitch_angle;
    modport source (output valid, roll_angle, pitch_angle, input ready);
    modport sink   (input valid, roll_angle, pitch_angle, output ready);
endinterface

// File: rtl/tilt_angle_lane.sv
// ============================================================================
// Tilt angle lane
// Pipelined root, vectoring CORDIC and rounding for one -atan2(num, |a,b|).
// ============================================================================
module tilt_angle_lane (
    input  logic                     clk,
    input  logic                     en,
    input  tilt_pkg::sample_t        num,
    input  tilt_pkg::sample_t        a,
    input  tilt_pkg::sample_t        b,
    output tilt_pkg::angle_t         angle
);
    import tilt_pkg::*;

    localparam int RT_STEPS = ROOT_W;          // one result bit per stage
    localparam int RAD_W    = SQ_W + 33;       // even width keeps bit pairs aligned
    localparam int LAT      = 1 + RT_STEPS + NUM_STAGES + 1;
    localparam int SH       = 30 - ANGLE_FRAC_BITS;

    // stage 0: squares
    logic [SQ_W-1:0] sq_reg;
    logic signed [15:0] num0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg   <= SQ_W'(unsigned'(32'(a * a))) + SQ_W'(unsigned'(32'(b * b)));
            num0_reg <= num;
        end
    end

    // restoring square root of sq * 2^32, one result bit per stage
    logic [RAD_W-1:0]    rad_reg [RT_STEPS+1];
    logic [ROOT_W+1:0]   rem_reg [RT_STEPS+1];
    logic [ROOT_W-1:0]   root_reg [RT_STEPS+1];
    logic signed [15:0]  numr_reg [RT_STEPS+1];

    always_comb
    begin
        rad_reg[0]  = {1'b0, sq_reg, 32'd0};
        rem_reg[0]  = '0;
        root_reg[0] = '0;
        numr_reg[0] = num0_reg;
    end

    for (genvar k = 0; k < RT_STEPS; k++)
    begin : g_root
        logic [ROOT_W+1:0] cur, trial;
        always_comb
        begin
            cur   = {rem_reg[k][ROOT_W-1:0], rad_reg[k][RAD_W-1 -: 2]};
            trial = {root_reg[k], 2'b01};
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rad_reg[k+1] <= {rad_reg[k][RAD_W-3:0], 2'b00};
                if (cur >= trial)
                begin
                    rem_reg[k+1]  <= cur - trial;
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[k+1]  <= cur;
                    root_reg[k+1] <= {root_reg[k][ROOT_W-2:0], 1'b0};
                end
                numr_reg[k+1] <= numr_reg[k];
            end
        end
    end

    // vectoring CORDIC
    logic signed [CV_W-1:0]  cx_reg [NUM_STAGES+1];
    logic signed [CV_W-1:0]  cy_reg [NUM_STAGES+1];
    logic signed [ANG_W-1:0] cz_reg [NUM_STAGES+1];
    logic                    nz_reg [NUM_STAGES+1];

    always_comb
    begin
        cx_reg[0] = CV_W'(root_reg[RT_STEPS]);
        cy_reg[0] = CV_W'(signed'({numr_reg[RT_STEPS], 16'd0}));
        cz_reg[0] = '0;
        nz_reg[0] = (numr_reg[RT_STEPS] == 16'sd0);
    end

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (cy_reg[i] < 0)
                begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - atan_q30(i);
                end
                else
                begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + atan_q30(i);
                end
                nz_reg[i+1] <= nz_reg[i];
            end
        end
    end

    // saturate, round magnitude, negate
    logic signed [ANG_W-1:0] zs;
    logic [ANG_W-1:0]        mag;
    logic [ANG_W-1:0]        rnd;
    angle_t                  angle_reg;

    always_comb
    begin
        zs = cz_reg[NUM_STAGES];
        if (zs > HALF_PI_Q30)
            zs = HALF_PI_Q30;
        else if (zs < -HALF_PI_Q30)
            zs = -HALF_PI_Q30;
        mag = (zs < 0) ? ANG_W'(-zs) : ANG_W'(zs);
        rnd = (mag + (ANG_W'(1) << (SH - 1))) >> SH;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (nz_reg[NUM_STAGES])
                angle_reg <= '0;
            else if (zs >= 0)
                angle_reg <= OUT_W'(-rnd);
            else
                angle_reg <= OUT_W'(rnd);
        end
    end

    assign angle = angle_reg;

    // LAT documents the lane depth; the top level computes its own copy
    localparam int LANE_LAT = LAT;
    if (LANE_LAT < 3)
    begin : g_bad
        $error("lane too short");
    end
endmodule

// File: rtl/accel_tilt_angles.sv
// ============================================================================
// Accelerometer tilt angles
// Offset, saturate and turn each sample into roll and pitch angles.
// ============================================================================
// Pipeline: 52 register stages (offset stage, squares, 33 root stages,
//   16 CORDIC stages, rounding); the skid stage adds no delay.
// Throughput: one word per cycle; the pipeline holds while the output skid
//   stage holds a word.
// Reset: valid bits and offsets clear to zero; data registers are not reset.
module accel_tilt_angles (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tilt_pkg::REG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                     cfg_data,
    tilt_sample_if.sink                     samples,
    tilt_angle_if.source                    angles
);
    import tilt_pkg::*;

    localparam int LAT = 1 + 1 + ROOT_W + NUM_STAGES + 1;

    sample_t x_offset_reg, y_offset_reg, z_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_offset_reg <= '0;
            y_offset_reg <= '0;
            z_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_X_OFFSET: x_offset_reg <= cfg_data;
                REG_Y_OFFSET: y_offset_reg <= cfg_data;
                REG_Z_OFFSET: z_offset_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    function automatic sample_t sat_add(input sample_t s, input sample_t o);
        logic signed [16:0] t;
        t = 17'(s) + 17'(o);
        if (t > 17'sd32767)
            return 16'sh7fff;
        else if (t < -17'sd32768)
            return 16'sh8000;
        else
            return t[15:0];
    endfunction

    // pipeline advances unless the skid stage holds a word
    logic skid_full_reg;
    logic en;
    logic [LAT-1:0] vld_reg;

    assign en = !skid_full_reg;
    assign samples.ready = en;

    sample_t x_reg, y_reg, z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= sat_add(samples.accel_x, x_offset_reg);
            y_reg <= sat_add(samples.accel_y, y_offset_reg);
            z_reg <= sat_add(samples.accel_z, z_offset_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], samples.valid};
    end

    angle_t roll, pitch;

    tilt_angle_lane u_roll (
        .clk   (clk),
        .en    (en),
        .num   (y_reg),
        .a     (x_reg),
        .b     (z_reg),
        .angle (roll)
    );

    tilt_angle_lane u_pitch (
        .clk   (clk),
        .en    (en),
        .num   (z_reg),
        .a     (x_reg),
        .b     (y_reg),
        .angle (pitch)
    );

    // output skid stage: capture the head word when blocked
    angle_t roll_skid_reg, pitch_skid_reg;
    logic   head_valid;

    assign head_valid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_full_reg <= 1'b0;
        else if (!skid_full_reg)
            skid_full_reg <= head_valid && !angles.ready;
        else if (angles.ready)
            skid_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            roll_skid_reg  <= roll;
            pitch_skid_reg <= pitch;
        end
    end

    assign angles.valid       = skid_full_reg || head_valid;
    assign angles.roll_angle  = skid_full_reg ? roll_skid_reg : roll;
    assign angles.pitch_angle = skid_full_reg ? pitch_skid_reg : pitch;

`ifndef SYNTHESIS
    a_stall_holds_valid: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(vld_reg))
        else $error("pipeline valid bits moved during a stall");
    a_skid_only_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_full_reg) |-> $past(head_valid) && !$past(angles.ready))
        else $error("skid stage filled without a blocked word");
    a_no_accept_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        skid_full_reg && !angles.ready |-> !samples.ready)
        else $error("input accepted while output blocked");
`endif
endmodule

// File: dv/tilt_test_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench interface notes
// The stream interfaces come from the RTL; this file follows the package in
// the file set and holds the testbench package with the sample and angle structs.
// ----------------------------------------------------------------------------
package tilt_test_pkg;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
    } tilt_sample_t;

    typedef struct packed {
        logic signed [14:0] roll;
        logic signed [14:0] pitch;
    } tilt_angles_t;

endpackage

// File: dv/accel_tilt_angles_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Accelerometer tilt angle testbench
// Drives offset settings and sample words with random gaps and sink stalls,
// predicts roll and pitch with a bit-exact CORDIC model and checks each word.
// ----------------------------------------------------------------------------
module accel_tilt_angles_test;
    import tilt_pkg::*;
    import tilt_test_pkg::*;

    localparam int LATENCY = 60;
    localparam int LIMIT   = 1000000;

    // index with no register behind it
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [15:0] cfg_data;

    tilt_sample_if samples();
    tilt_angle_if  angles();

    accel_tilt_angles dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .samples   (samples.sink),
        .angles    (angles.source)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Predictor copy of the offsets
    logic signed [15:0] off_x, off_y, off_z;

    tilt_angles_t angle_queue[$];
    int  fail_count = 0;
    int  cycle_count = 0;
    bit  long_stall = 1'b0;
    bit  sink_hold;

    function automatic logic signed [15:0] sat_add(logic signed [15:0] a,
                                                  logic signed [15:0] b);
        int s;
        s = int'(a) + int'(b);
        if (s > 32767) return 16'sd32767;
        if (s < -32768) return -16'sd32768;
        return 16'(s);
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Negated atan2(num, sqrt(a*a + b*b)) in Q2.13
    function automatic logic signed [14:0] tilt_angle(int num, int a, int b);
        longint unsigned sq;
        longint xv, yv, zacc, dx, dy, mag, r;
        sq = longint'(a) * a + longint'(b) * b;
        xv = longint'(int_sqrt(sq << 32));
        yv = longint'(num) * 65536;
        zacc = 0;
        if (num == 0) return '0;
        for (int i = 0; i < NUM_STAGES; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv < 0)
            begin
                xv = xv - dx;
                yv = yv + dy;
                zacc = zacc - longint'(atan_q30(i));
            end
            else
            begin
                xv = xv + dx;
                yv = yv - dy;
                zacc = zacc + longint'(atan_q30(i));
            end
        end
        if (zacc > longint'(HALF_PI_Q30)) zacc = longint'(HALF_PI_Q30);
        if (zacc < -longint'(HALF_PI_Q30)) zacc = -longint'(HALF_PI_Q30);
        mag = (zacc < 0) ? -zacc : zacc;
        r = (mag + (64'd1 << (29 - ANGLE_FRAC_BITS))) >> (30 - ANGLE_FRAC_BITS);
        return (zacc >= 0) ? 15'(-r) : 15'(r);
    endfunction

    function automatic tilt_angles_t predict_angles(tilt_sample_t s);
        tilt_angles_t res;
        int x, y, z;
        x = sat_add(s.ax, off_x);
        y = sat_add(s.ay, off_y);
        z = sat_add(s.az, off_z);
        res.roll  = tilt_angle(y, x, z);
        res.pitch = tilt_angle(z, x, y);
        return res;
    endfunction

    task automatic write_offset(logic [REG_IDX_W-1:0] idx, logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_X_OFFSET: off_x = val;
            REG_Y_OFFSET: off_y = val;
            REG_Z_OFFSET: off_z = val;
            default: ;
        endcase
    endtask

    task automatic set_offsets(logic [15:0] x, logic [15:0] y, logic [15:0] z);
        write_offset(REG_X_OFFSET, x);
        write_offset(REG_Y_OFFSET, y);
        write_offset(REG_Z_OFFSET, z);
    endtask

    task automatic wait_drained();
        while (angle_queue.size() != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    // Offer one word (at the falling edge) and hold until taken
    task automatic send_sample(tilt_sample_t s);
        samples.valid   <= 1'b1;
        samples.accel_x <= s.ax;
        samples.accel_y <= s.ay;
        samples.accel_z <= s.az;
        @(posedge clk);
        while (!samples.ready) @(posedge clk);
        angle_queue.push_back(predict_angles(s));
        @(negedge clk);
    endtask

    task automatic idle_gap(int n);
        samples.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    function automatic logic signed [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'($urandom_range(0, 7)) - 16'sd3;
            default: return 16'($urandom);
        endcase
    endfunction

    // Directed rows: expected value typed in where obvious
    typedef struct {
        logic signed [15:0] ax, ay, az;
        bit known;
        logic signed [14:0] roll, pitch;
    } dir_row_t;

    dir_row_t dir_rows[] = '{
        '{16'sd0, 16'sd0, 16'sd0, 1'b1, 15'sd0, 15'sd0},
        '{16'sd100, 16'sd0, 16'sd0, 1'b1, 15'sd0, 15'sd0},
        '{16'sd0, 16'sd1000, 16'sd0, 1'b0, 15'sd0, 15'sd0},
        '{16'sd0, -16'sd1000, 16'sd0, 1'b0, 15'sd0, 15'sd0},
        '{16'sd0, 16'sd0, 16'sd1000, 1'b0, 15'sd0, 15'sd0},
        '{16'sd0, 16'sd0, -16'sd1000, 1'b0, 15'sd0, 15'sd0},
        '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b0, 15'sd0, 15'sd0},
        '{16'sh8000, 16'sh8000, 16'sh8000, 1'b0, 15'sd0, 15'sd0},
        '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 1'b0, 15'sd0, 15'sd0},
        '{16'sh8000, 16'sh7FFF, 16'sh8000, 1'b0, 15'sd0, 15'sd0},
        '{16'sd1, 16'sd1, 16'sd1, 1'b0, 15'sd0, 15'sd0},
        '{-16'sd1, -16'sd1, -16'sd1, 1'b0, 15'sd0, 15'sd0},
        '{16'sd0, 16'sd1, 16'sh8000, 1'b0, 15'sd0, 15'sd0},
        '{16'sd3000, 16'sd4000, -16'sd5000, 1'b0, 15'sd0, 15'sd0},
        '{16'sh5555, 16'shAAAA, 16'sh1234, 1'b0, 15'sd0, 15'sd0}
    };

    // Sink: random stalls, plus one long hold set by the main sequence
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            angles.ready <= 1'b0;
        else if (sink_hold)
            angles.ready <= 1'b0;
        else if (long_stall)
            angles.ready <= ($urandom_range(0, 3) != 0);
        else
            angles.ready <= 1'b1;
    end

    // Alternate stall-heavy and stall-free stretches
    always @(negedge clk)
    begin
        if (($urandom_range(0, 199)) == 0) long_stall <= ~long_stall;
    end

    // Check every taken angle word
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (angles.valid && angles.ready)
            begin
                if (angle_queue.size() == 0)
                begin
                    $error("unexpected angle word roll=%0d pitch=%0d",
                           angles.roll_angle, angles.pitch_angle);
                    fail_count++;
                end
                else
                begin
                    tilt_angles_t exp_a;
                    exp_a = angle_queue.pop_front();
                    if (angles.roll_angle !== exp_a.roll)
                    begin
                        $error("roll_angle expected %0d actual %0d",
                               exp_a.roll, angles.roll_angle);
                        fail_count++;
                    end
                    if (angles.pitch_angle !== exp_a.pitch)
                    begin
                        $error("pitch_angle expected %0d actual %0d",
                               exp_a.pitch, angles.pitch_angle);
                        fail_count++;
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (cycle_count > LIMIT)
        begin
            $display("accel_tilt_angles_test: errors");
            $finish;
        end
    end

    initial
    begin
        tilt_sample_t s;
        int burst;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        samples.valid = 1'b0;
        samples.accel_x = '0;
        samples.accel_y = '0;
        samples.accel_z = '0;
        off_x = '0;
        off_y = '0;
        off_z = '0;
        sink_hold = 1'b0;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            s.ax = dir_rows[i].ax;
            s.ay = dir_rows[i].ay;
            s.az = dir_rows[i].az;
            send_sample(s);
            if (dir_rows[i].known)
                angle_queue[$] = '{roll: dir_rows[i].roll, pitch: dir_rows[i].pitch};
        end
        idle_gap(1);
        wait_drained();

        // Offsets at the extremes: saturation on every axis
        set_offsets(16'sh7FFF, 16'sh8000, 16'sh7FFF);
        s = '{ax: 16'sh7FFF, ay: 16'sh8000, az: 16'sd5};
        send_sample(s);
        s = '{ax: 16'sh8000, ay: 16'sh7FFF, az: 16'sh8000};
        send_sample(s);
        idle_gap(1);
        wait_drained();
        // Unknown register index is ignored
        write_offset(REG_UNUSED, 16'h1234);

        // Long sink hold while the source keeps offering: pipeline fills
        sink_hold = 1'b1;
        fork
            begin
                repeat (150) @(negedge clk);
                sink_hold = 1'b0;
            end
            for (int i = 0; i < 100; i++)
            begin
                s = '{ax: rand_field(), ay: rand_field(), az: rand_field()};
                send_sample(s);
            end
        join
        idle_gap(1);
        wait_drained();

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 5)
                set_offsets(16'h8000, 16'h7FFF, 16'h8000);
            else
                set_offsets(rand_field(), rand_field(), rand_field());
            for (int n = 0; n < 200;)
            begin
                burst = $urandom_range(1, 30);
                for (int k = 0; k < burst; k++)
                begin
                    s = '{ax: rand_field(), ay: rand_field(), az: rand_field()};
                    send_sample(s);
                    n++;
                end
                if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 8));
            end
            idle_gap(1);
            wait_drained();
        end

        if (fail_count == 0)
            $display("accel_tilt_angles_test: clean");
        else
            $display("accel_tilt_angles_test: errors");
        $finish;
    end

endmodule

// File: sim.f
rtl/tilt_pkg.sv
rtl/tilt_if.sv
rtl/tilt_angle_lane.sv
rtl/accel_tilt_angles.sv
dv/tilt_test_if.sv
dv/accel_tilt_angles_test.sv
